FILE: sv/drfp_pkg.sv
package drfp_pkg;

  // Frame markers and command codes
  localparam logic [7:0] SyncFirst  = 8'h5A;
  localparam logic [7:0] SyncSecond = 8'hA5;
  localparam logic [7:0] CmdRead    = 8'h83;
  localparam logic [7:0] MinReadLen = 8'd5;

  // Default receive buffer size in bytes
  localparam int unsigned DefaultBufferBytes = 64;

  // One decoded beat headed for the output register
  typedef struct packed {
    logic        valid;
    logic [15:0] address;
    logic [15:0] value;
  } drfp_result_t;

  // Byte beat held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       burst_end;
  } drfp_beat_t;

endpackage

FILE: sv/drfp_in_stage.sv
module drfp_in_stage
  import drfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       burst_end_i,
  input  logic       out_free_i,
  output logic       advance_o,
  output drfp_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  // Move the held beat on whenever the output register can take a result
  assign advance_o  = valid_q && out_free_i;
  assign in_ready_o = !valid_q || advance_o;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
      last_q <= burst_end_i;
    end
  end

  assign beat_o = '{valid: valid_q, rx_byte: byte_q, burst_end: last_q};

endmodule

FILE: sv/drfp_parser.sv
module drfp_parser
  import drfp_pkg::*;
#(
  parameter int unsigned BufferBytes = DefaultBufferBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  drfp_beat_t   beat_i,
  output drfp_result_t result_o
);

  localparam int unsigned CntW = $clog2(BufferBytes + 1);

  typedef enum logic [1:0] {
    PhHunt1,
    PhHunt2,
    PhLen,
    PhBody
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  offset_q, offset_d;
  logic        read_q, read_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]  b;
  logic        frame_done;

  assign b = beat_i.rx_byte;

  // Parse one byte
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    offset_d   = offset_q;
    read_d     = read_q;
    addr_d     = addr_q;
    tail_d     = tail_q;
    count_d    = count_q;
    frame_done = 1'b0;
    result_o   = '{valid: 1'b0, address: addr_q, value: tail_q};

    if (count_q < CntW'(BufferBytes)) begin
      count_d = count_q + CntW'(1);
      unique case (phase_q)
        PhHunt1: begin
          if (b == SyncFirst) phase_d = PhHunt2;
        end
        PhHunt2: begin
          if (b == SyncSecond) begin
            phase_d = PhLen;
          end else if (b != SyncFirst) begin
            phase_d = PhHunt1;
          end
        end
        PhLen: begin
          len_d    = b;
          offset_d = '0;
          read_d   = 1'b0;
          addr_d   = '0;
          tail_d   = '0;
          phase_d  = (b == 8'd0) ? PhHunt1 : PhBody;
        end
        PhBody: begin
          if (offset_q == 8'd0) begin
            read_d = (b == CmdRead);
          end else if (offset_q <= 8'd2) begin
            addr_d = {addr_q[7:0], b};
          end
          tail_d = {tail_q[7:0], b};
          // Close the frame on its last body byte
          if ({1'b0, offset_q} + 9'd1 >= {1'b0, len_q}) begin
            frame_done = 1'b1;
            phase_d    = PhHunt1;
            offset_d   = '0;
          end else begin
            offset_d = offset_q + 8'd1;
          end
        end
        default: phase_d = PhHunt1;
      endcase
    end

    result_o.valid   = frame_done && read_d && (len_q >= MinReadLen);
    result_o.address = addr_d;
    result_o.value   = tail_d;

    // Drop everything at the end of a burst
    if (beat_i.burst_end) begin
      phase_d  = PhHunt1;
      len_d    = '0;
      offset_d = '0;
      read_d   = 1'b0;
      addr_d   = '0;
      tail_d   = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt1;
      len_q    <= '0;
      offset_q <= '0;
      read_q   <= 1'b0;
      addr_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      offset_q <= offset_d;
      read_q   <= read_d;
      addr_q   <= addr_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: sv/drfp_out_stage.sv
module drfp_out_stage
  import drfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  drfp_result_t result_i,
  output logic         out_free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [15:0]  var_address_o,
  output logic [15:0]  var_value_o
);

  logic        valid_q, valid_d;
  logic [15:0] addr_q;
  logic [15:0] value_q;
  logic        load;

  assign out_free_o = !valid_q || out_ready_i;
  assign load       = advance_i && result_i.valid;

  // Hold the result until the receiver takes it
  always_comb begin
    valid_d = valid_q;
    if (out_free_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q  <= result_i.address;
      value_q <= result_i.value;
    end
  end

  assign out_valid_o   = valid_q;
  assign var_address_o = addr_q;
  assign var_value_o   = value_q;

endmodule

FILE: sv/display_reply_frame_parser_core.sv
// Reply frame parser for a serial display link.
//
// Input channel: one received byte per beat (rx_byte_i) with burst_end_i set
// on the last byte of a receive burst; in_valid_i / in_ready_o handshake.
// Output channel: one beat per completed read reply frame (command 0x83,
// length at least 5) carrying var_address_o and var_value_o; out_valid_o /
// out_ready_i handshake. Other frames produce no beat.
//
// Path: a byte accepted lands in the input register, the combinational parse
// step reads it there, and its result is loaded into the output register when
// the input register advances, which waits until the output register is free.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single parse step between the input register and the output register.
// Reset: returns the parser to hunting for the first sync byte with an empty
// burst count; both registers are emptied.
// Receiver stall: the result stays in the output register; one more byte may
// wait in the input register, after which in_ready_o drops.
module display_reply_frame_parser_core
  import drfp_pkg::*;
#(
  parameter int unsigned BufferBytes = DefaultBufferBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        burst_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] var_address_o,
  output logic [15:0] var_value_o
);

  drfp_beat_t   beat;
  drfp_result_t result;
  logic         advance;
  logic         out_free;

  drfp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .burst_end_i (burst_end_i),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .beat_o      (beat)
  );

  drfp_parser #(
    .BufferBytes (BufferBytes)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .beat_i    (beat),
    .result_o  (result)
  );

  drfp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .result_i      (result),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .var_address_o (var_address_o),
    .var_value_o   (var_value_o)
  );

endmodule

FILE: sv/drfp_checker.sv
module drfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] var_address_o,
  input logic [15:0] var_value_o
);

  // Result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(var_address_o) && $stable(var_value_o))
    else $error("result payload changed while stalled");

  // A fresh result must trace back to an accepted input byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input byte");

  // No result right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

endmodule

bind display_reply_frame_parser_core drfp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .var_address_o (var_address_o),
  .var_value_o   (var_value_o)
);
